/* rtl/prim_minimum_spanning_tree_defines.svh */
// assertion helpers shared by the spanning tree rtl
`ifndef PRIM_MINIMUM_SPANNING_TREE_DEFINES_SVH
`define PRIM_MINIMUM_SPANNING_TREE_DEFINES_SVH

// same-cycle implication, checked on clk with reset masked
`define PMST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk with reset masked
`define PMST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pmst_pkg.sv */
package pmst_pkg;

    localparam int WEIGHT_W = 15;
    localparam int FIELD_VERTEX_W = 4;
    localparam int VCOUNT_W = 5;

    localparam logic [WEIGHT_W-1:0] NO_EDGE = 15'h7FFF;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

    // command carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic clear;   // reset running minimum before a sweep
        logic rd_en;   // read one column of the best arrays
        logic init;    // sweep loads the start row instead of relaxing
    } scan_ctl_t;

endpackage

/* rtl/pmst_scan.sv */
`include "prim_minimum_spanning_tree_defines.svh"

module pmst_scan #(
    parameter int MAX_VERTICES = 16,
    parameter int VW = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pmst_pkg::scan_ctl_t            ctl,
    input  logic [VW-1:0]                  rd_idx,
    input  logic [VW-1:0]                  pick,
    input  logic [pmst_pkg::WEIGHT_W-1:0]  adj_q,
    output logic [pmst_pkg::WEIGHT_W-1:0]  low,
    output logic [VW-1:0]                  cand,
    output logic [VW-1:0]                  cand_parent,
    output logic                           found
);

    logic [pmst_pkg::WEIGHT_W-1:0] best_w [MAX_VERTICES];
    logic [VW-1:0]                 best_p [MAX_VERTICES];

    logic [pmst_pkg::WEIGHT_W-1:0] bw_q_reg;
    logic [VW-1:0]                 bp_q_reg;
    logic [VW-1:0]                 j_d_reg;
    logic                          v_d_reg;

    logic [pmst_pkg::WEIGHT_W-1:0] low_reg;
    logic [VW-1:0]                 cand_reg;
    logic [VW-1:0]                 cand_parent_reg;
    logic                          found_reg;

    logic [pmst_pkg::WEIGHT_W-1:0] bw_eff;
    logic [pmst_pkg::WEIGHT_W-1:0] new_w;
    logic [VW-1:0]                 new_p;
    logic                          take;

    // the picked vertex joins the tree before its row relaxes the rest
    always_comb
    begin
        bw_eff = (j_d_reg == pick) ? '0 : bw_q_reg;
        if (ctl.init)
        begin
            new_w = (j_d_reg == pick) ? '0 : adj_q;
            new_p = pick;
        end
        else if (adj_q < bw_eff)
        begin
            new_w = adj_q;
            new_p = pick;
        end
        else
        begin
            new_w = bw_eff;
            new_p = bp_q_reg;
        end
        take = v_d_reg && (new_w != '0) && (new_w < low_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            bw_q_reg <= best_w[rd_idx];
            bp_q_reg <= best_p[rd_idx];
        end
        if (v_d_reg)
        begin
            best_w[j_d_reg] <= new_w;
            best_p[j_d_reg] <= new_p;
        end
        j_d_reg <= rd_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_d_reg         <= 1'b0;
            low_reg         <= pmst_pkg::NO_EDGE;
            cand_reg        <= '0;
            cand_parent_reg <= '0;
            found_reg       <= 1'b0;
        end
        else
        begin
            v_d_reg <= ctl.rd_en;
            if (ctl.clear)
            begin
                low_reg   <= pmst_pkg::NO_EDGE;
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                low_reg         <= new_w;
                cand_reg        <= j_d_reg;
                cand_parent_reg <= new_p;
                found_reg       <= 1'b1;
            end
        end
    end

    assign low         = low_reg;
    assign cand        = cand_reg;
    assign cand_parent = cand_parent_reg;
    assign found       = found_reg;

    `PMST_ASSERT_NOW(a_found_low, found_reg, (low_reg != '0) && (low_reg != pmst_pkg::NO_EDGE), "found minimum out of range")
    `PMST_ASSERT_NOW(a_empty_low, !found_reg, low_reg == pmst_pkg::NO_EDGE, "minimum moved without a candidate")
    `PMST_ASSERT_NEXT(a_clear, ctl.clear, !found_reg, "clear did not drop the candidate")

endmodule

/* rtl/prim_minimum_spanning_tree.sv */
// Prim spanning tree engine. A load transaction (tuser = 0) writes one weight of the
// adjacency matrix. A run transaction (tuser = 1) names the start vertex; the block
// then sweeps one matrix row per tree edge, reading one weight a cycle from the
// single-port matrix memory through one shared relax/minimum unit, so a run holds
// s_tready low until its last result is loaded, also while the output waits on
// m_tready. Edges come out in the order they join the tree, tlast on the final one;
// an unreachable remainder or a bad start vertex ends the run with one result
// flagged disconnected on m_tuser. Weight 32767 means no edge.
`include "prim_minimum_spanning_tree_defines.svh"

module prim_minimum_spanning_tree #(
    parameter int MAX_VERTICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row[3:0], col[7:4], weight[22:8], start_vertex[26:23], zero[31:27]
    input  logic [31:0] s_tdata,
    // command[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // from_vertex[3:0], to_vertex[7:4], edge_weight[22:8], zero[23]
    output logic [23:0] m_tdata,
    // disconnected[0]
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int ADJ_DEPTH = 2 ** (2 * VW);
    localparam int WW = pmst_pkg::WEIGHT_W;
    localparam int FW = pmst_pkg::FIELD_VERTEX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT,
        ST_SHORT
    } state_t;

    state_t state_reg;

    logic [pmst_pkg::VCOUNT_W-1:0] vc_reg;
    logic [NW-1:0]                 n_reg;
    logic [VW-1:0]                 pick_reg;
    logic [VW-1:0]                 j_reg;
    logic [VW-1:0]                 edges_reg;
    logic                          init_reg;
    logic                          short_disc_reg;

    logic                          m_tvalid_reg;
    logic [FW-1:0]                 out_from_reg;
    logic [FW-1:0]                 out_to_reg;
    logic [WW-1:0]                 out_w_reg;
    logic                          out_disc_reg;
    logic                          out_last_reg;

    logic [WW-1:0]                 adj_mem [ADJ_DEPTH];
    logic [WW-1:0]                 adj_q_reg;

    logic [FW-1:0]                 in_row;
    logic [FW-1:0]                 in_col;
    logic [WW-1:0]                 in_weight;
    logic [FW-1:0]                 in_start;

    logic                          in_acc;
    logic                          run_acc;
    logic                          adj_we;
    logic                          cfg_we;
    logic                          slot_free;
    logic                          out_load;
    logic [NW-1:0]                 n_eff;
    logic                          start_bad;
    logic                          run_short;
    logic                          last_j;
    logic                          edge_last;
    logic                          emit_more;

    pmst_pkg::scan_ctl_t           ctl;
    logic [WW-1:0]                 scan_low;
    logic [VW-1:0]                 scan_cand;
    logic [VW-1:0]                 scan_parent;
    logic                          scan_found;

    assign in_row    = s_tdata[3:0];
    assign in_col    = s_tdata[7:4];
    assign in_weight = s_tdata[22:8];
    assign in_start  = s_tdata[26:23];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign run_acc   = in_acc && (s_tuser == pmst_pkg::CMD_RUN);
    assign adj_we    = in_acc && (s_tuser == pmst_pkg::CMD_LOAD)
                       && (32'(in_row) < MAX_VERTICES) && (32'(in_col) < MAX_VERTICES);
    assign slot_free = !m_tvalid_reg || m_tready;
    assign out_load  = ((state_reg == ST_EMIT) || (state_reg == ST_SHORT)) && slot_free;

    // effective vertex count, zero acts as one and counts above MAX_VERTICES clamp to it
    always_comb
    begin
        if (vc_reg == '0)
            n_eff = NW'(1);
        else if (32'(vc_reg) > MAX_VERTICES)
            n_eff = NW'(MAX_VERTICES);
        else
            n_eff = NW'(vc_reg);
    end

    assign start_bad = 32'(in_start) >= 32'(n_eff);
    assign run_short = start_bad || (n_eff == NW'(1));
    assign last_j    = (32'(j_reg) + 32'd1) == 32'(n_reg);
    assign edge_last = (32'(edges_reg) + 32'd2) == 32'(n_reg);
    assign emit_more = (state_reg == ST_EMIT) && slot_free && scan_found && !edge_last;

    assign ctl.clear = (run_acc && !run_short) || emit_more;
    assign ctl.rd_en = (state_reg == ST_SWEEP);
    assign ctl.init  = init_reg;

    // apb register
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == pmst_pkg::REG_VERTEX_COUNT);
    assign prdata = (paddr[2] == pmst_pkg::REG_VERTEX_COUNT)
                    ? {{(32 - pmst_pkg::VCOUNT_W){1'b0}}, vc_reg} : '0;

    always_ff @(posedge clk)
    begin
        if (adj_we)
            adj_mem[{VW'(in_row), VW'(in_col)}] <= in_weight;
        if (ctl.rd_en)
            adj_q_reg <= adj_mem[{pick_reg, j_reg}];
    end

    pmst_scan #(
        .MAX_VERTICES (MAX_VERTICES),
        .VW           (VW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .rd_idx      (j_reg),
        .pick        (pick_reg),
        .adj_q       (adj_q_reg),
        .low         (scan_low),
        .cand        (scan_cand),
        .cand_parent (scan_parent),
        .found       (scan_found)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            vc_reg         <= pmst_pkg::VCOUNT_RESET;
            n_reg          <= '0;
            pick_reg       <= '0;
            j_reg          <= '0;
            edges_reg      <= '0;
            init_reg       <= 1'b0;
            short_disc_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            out_from_reg   <= '0;
            out_to_reg     <= '0;
            out_w_reg      <= '0;
            out_disc_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                vc_reg <= pwdata[pmst_pkg::VCOUNT_W-1:0];
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (run_acc)
                    begin
                        n_reg          <= n_eff;
                        pick_reg       <= VW'(in_start);
                        j_reg          <= '0;
                        edges_reg      <= '0;
                        init_reg       <= 1'b1;
                        short_disc_reg <= start_bad;
                        state_reg      <= run_short ? ST_SHORT : ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    j_reg <= j_reg + 1'b1;
                    if (last_j)
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        if (!scan_found)
                        begin
                            out_from_reg <= '0;
                            out_to_reg   <= '0;
                            out_w_reg    <= '0;
                            out_disc_reg <= 1'b1;
                            out_last_reg <= 1'b1;
                            state_reg    <= ST_IDLE;
                        end
                        else
                        begin
                            out_from_reg <= FW'(scan_parent);
                            out_to_reg   <= FW'(scan_cand);
                            out_w_reg    <= scan_low;
                            out_disc_reg <= 1'b0;
                            out_last_reg <= edge_last;
                            if (edge_last)
                                state_reg <= ST_IDLE;
                            else
                            begin
                                pick_reg  <= scan_cand;
                                j_reg     <= '0;
                                edges_reg <= edges_reg + 1'b1;
                                init_reg  <= 1'b0;
                                state_reg <= ST_SWEEP;
                            end
                        end
                    end
                end
                ST_SHORT:
                begin
                    if (slot_free)
                    begin
                        out_from_reg <= '0;
                        out_to_reg   <= '0;
                        out_w_reg    <= '0;
                        out_disc_reg <= short_disc_reg;
                        out_last_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_w_reg, out_to_reg, out_from_reg};
    assign m_tuser  = out_disc_reg;
    assign m_tlast  = out_last_reg;

    `PMST_ASSERT_NEXT(a_disc_ends, (state_reg == ST_EMIT) && slot_free && !scan_found, (state_reg == ST_IDLE) && m_tvalid && m_tlast && m_tuser, "disconnected result did not end the run")
    `PMST_ASSERT_NOW(a_edge_bound, state_reg == ST_SWEEP, (32'(edges_reg) + 32'd2) <= 32'(n_reg), "edge count past vertex count")
    `PMST_ASSERT_NOW(a_port_share, adj_we, !ctl.rd_en, "matrix load during a sweep")
    `PMST_ASSERT_NEXT(a_more_sweeps, emit_more, (state_reg == ST_SWEEP) && (j_reg == '0) && !m_tlast, "next sweep did not start after an inner edge")

endmodule

/* sim/tb_prim_minimum_spanning_tree.sv */
`timescale 1ns / 100ps

module tb_prim_minimum_spanning_tree;

    localparam int RANDOM_ITEMS   = 150;
    localparam int SETTLE_CYCLES  = 24;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int IDLE_PCT       = 23;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // row[3:0], col[7:4], weight[22:8], start_vertex[26:23], zero[31:27]
    logic [31:0] s_tdata;
    // command[0]
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // from_vertex[3:0], to_vertex[7:4], edge_weight[22:8], zero[23]
    logic [23:0] m_tdata;
    // disconnected[0]
    logic        m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    prim_minimum_spanning_tree dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    typedef struct packed {
        logic [pmst_pkg::FIELD_VERTEX_W-1:0] from_v;
        logic [pmst_pkg::FIELD_VERTEX_W-1:0] to_v;
        logic [pmst_pkg::WEIGHT_W-1:0]       weight;
        logic                                disc;
        logic                                last;
    } tree_edge_t;

    class mst_scoreboard;
        logic [pmst_pkg::WEIGHT_W-1:0] adjacency [16][16];
        int unsigned                   vertex_count = 32'(pmst_pkg::VCOUNT_RESET);
        tree_edge_t                    pending_edges [$];
        int unsigned                   fails = 0;

        function void set_vertex_count(logic [pmst_pkg::VCOUNT_W-1:0] value);
            vertex_count = 32'(value);
        endfunction

        function void push_edge(logic [pmst_pkg::FIELD_VERTEX_W-1:0] f,
                                logic [pmst_pkg::FIELD_VERTEX_W-1:0] t,
                                logic [pmst_pkg::WEIGHT_W-1:0] w, logic d, logic l);
            tree_edge_t e;
            e.from_v = f;
            e.to_v   = t;
            e.weight = w;
            e.disc   = d;
            e.last   = l;
            pending_edges.push_back(e);
        endfunction

        // prim over the first n vertices, lowest index wins ties
        function void grow_tree(logic [pmst_pkg::FIELD_VERTEX_W-1:0] start);
            logic [pmst_pkg::WEIGHT_W-1:0]       best_w [16];
            logic [pmst_pkg::FIELD_VERTEX_W-1:0] best_p [16];
            logic [pmst_pkg::WEIGHT_W-1:0]       low;
            int  n;
            int  s;
            int  pick;
            bit  found;
            n = int'(vertex_count);
            s = int'(start);
            if (n < 1)
                n = 1;
            if (n > 16)
                n = 16;
            if (s >= n)
            begin
                push_edge(4'd0, 4'd0, '0, 1'b1, 1'b1);
                return;
            end
            if (n == 1)
            begin
                push_edge(4'd0, 4'd0, '0, 1'b0, 1'b1);
                return;
            end
            for (int j = 0; j < n; j++)
            begin
                best_w[j] = adjacency[s][j];
                best_p[j] = start;
            end
            // the root joins the tree whatever its diagonal holds
            best_w[s] = '0;
            for (int i = 0; i + 1 < n; i++)
            begin
                low   = pmst_pkg::NO_EDGE;
                pick  = 0;
                found = 1'b0;
                for (int j = 0; j < n; j++)
                begin
                    if (best_w[j] != 0 && best_w[j] < low)
                    begin
                        low   = best_w[j];
                        pick  = j;
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    push_edge(4'd0, 4'd0, '0, 1'b1, 1'b1);
                    return;
                end
                push_edge(best_p[pick], pick[pmst_pkg::FIELD_VERTEX_W-1:0], low, 1'b0,
                          (i + 2 == n));
                best_w[pick] = '0;
                for (int j = 0; j < n; j++)
                begin
                    if (adjacency[pick][j] < best_w[j])
                    begin
                        best_w[j] = adjacency[pick][j];
                        best_p[j] = pick[pmst_pkg::FIELD_VERTEX_W-1:0];
                    end
                end
            end
        endfunction

        function void note_transaction(logic cmd, logic [3:0] row, logic [3:0] col,
                                       logic [pmst_pkg::WEIGHT_W-1:0] w,
                                       logic [3:0] start);
            if (cmd == pmst_pkg::CMD_LOAD)
                adjacency[row][col] = w;
            else
                grow_tree(start);
        endfunction

        function void check_edge(tree_edge_t got);
            tree_edge_t exp;
            if (pending_edges.size() == 0)
            begin
                $error("result with nothing expected: from %0d to %0d weight %0d",
                       got.from_v, got.to_v, got.weight);
                fails++;
                return;
            end
            exp = pending_edges.pop_front();
            if (got.from_v !== exp.from_v)
            begin
                $error("from_vertex expected %0d actual %0d", exp.from_v, got.from_v);
                fails++;
            end
            if (got.to_v !== exp.to_v)
            begin
                $error("to_vertex expected %0d actual %0d", exp.to_v, got.to_v);
                fails++;
            end
            if (got.weight !== exp.weight)
            begin
                $error("edge_weight expected %0d actual %0d", exp.weight, got.weight);
                fails++;
            end
            if (got.disc !== exp.disc)
            begin
                $error("disconnected expected %0d actual %0d", exp.disc, got.disc);
                fails++;
            end
            if (got.last !== exp.last)
            begin
                $error("last expected %0d actual %0d", exp.last, got.last);
                fails++;
            end
        endfunction
    endclass

    mst_scoreboard sb = new;
    bit quiet = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= (quiet || $urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_edge(tree_edge_t'{m_tdata[3:0], m_tdata[7:4], m_tdata[22:8],
                                       m_tuser, m_tlast});
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_prim_minimum_spanning_tree NOT OK");
                $finish;
            end
        end
    end

    task automatic send_item(logic cmd, int row, int col, int w, int start);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, start[3:0], w[pmst_pkg::WEIGHT_W-1:0], col[3:0], row[3:0]};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_transaction(cmd, row[3:0], col[3:0], w[pmst_pkg::WEIGHT_W-1:0], start[3:0]);
        items_sent++;
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            gap = $urandom_range(1, 2);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_tree(int start);
        send_item(pmst_pkg::CMD_RUN, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 32767), start);
    endtask

    // no register writes until every edge is out and the engine has gone quiet
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (sb.pending_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(int value);
        settle_block();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {pmst_pkg::REG_VERTEX_COUNT, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_vertex_count(value[pmst_pkg::VCOUNT_W-1:0]);
    endtask

    function automatic int pick_weight(int sparse_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < sparse_pct)
            return int'(pmst_pkg::NO_EDGE);
        r = $urandom_range(0, 99);
        if (r < 6)
            return 0;
        if (r < 30)
            return $urandom_range(0, 32767);
        return $urandom_range(1, 9);
    endfunction

    // fills the whole n x n corner so a run never touches an unwritten weight
    task automatic load_graph(int n, bit mirror, int sparse_pct);
        int w;
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                if (r == c)
                begin
                    w = ($urandom_range(0, 9) == 0) ? pick_weight(sparse_pct) : 0;
                    send_item(pmst_pkg::CMD_LOAD, r, c, w, $urandom_range(0, 15));
                end
                else if (!mirror)
                    send_item(pmst_pkg::CMD_LOAD, r, c, pick_weight(sparse_pct),
                              $urandom_range(0, 15));
                else if (c > r)
                begin
                    w = pick_weight(sparse_pct);
                    send_item(pmst_pkg::CMD_LOAD, r, c, w, $urandom_range(0, 15));
                    send_item(pmst_pkg::CMD_LOAD, c, r, w, $urandom_range(0, 15));
                end
            end
        end
    endtask

    initial
    begin
        int n;
        int roll;
        int cur_count;
        int random_start;
        int graph_idx;
        int sparse_pct;
        int r;
        int c;
        int edge_w;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= pmst_pkg::CMD_LOAD;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single vertex, bad start, and a count of zero behaving as one
        write_vertex_count(1);
        run_tree(0);
        run_tree(15);
        write_vertex_count(0);
        run_tree(0);

        // three vertices: weight extremes, no edge, root with nonzero diagonal
        write_vertex_count(3);
        send_item(pmst_pkg::CMD_LOAD, 0, 0, 0, 0);
        send_item(pmst_pkg::CMD_LOAD, 1, 1, 0, 15);
        send_item(pmst_pkg::CMD_LOAD, 2, 2, int'(pmst_pkg::NO_EDGE), 0);
        send_item(pmst_pkg::CMD_LOAD, 0, 1, int'(pmst_pkg::NO_EDGE) - 1, 0);
        send_item(pmst_pkg::CMD_LOAD, 1, 0, int'(pmst_pkg::NO_EDGE) - 1, 0);
        send_item(pmst_pkg::CMD_LOAD, 0, 2, int'(pmst_pkg::NO_EDGE), 0);
        send_item(pmst_pkg::CMD_LOAD, 2, 0, int'(pmst_pkg::NO_EDGE), 0);
        send_item(pmst_pkg::CMD_LOAD, 1, 2, 1, 0);
        send_item(pmst_pkg::CMD_LOAD, 2, 1, 1, 0);
        run_tree(2);
        run_tree(0);
        run_tree(3);
        // zero off the diagonal pulls vertex 1 in silently, leaving 2 unreachable
        send_item(pmst_pkg::CMD_LOAD, 0, 1, 0, 0);
        run_tree(0);
        cur_count = 3;

        graph_idx    = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                n = 1;
            else if (roll < 80)
                n = $urandom_range(2, 5);
            else
                n = $urandom_range(6, 9);
            quiet = (graph_idx == 2) || ($urandom_range(0, 9) == 0);
            if (n != cur_count)
            begin
                write_vertex_count(n);
                cur_count = n;
            end
            case ($urandom_range(0, 2))
                0: sparse_pct = 5;
                1: sparse_pct = 30;
                default: sparse_pct = 70;
            endcase
            load_graph(n, $urandom_range(0, 4) != 0, sparse_pct);
            repeat ($urandom_range(0, 2))
                send_item(pmst_pkg::CMD_LOAD, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 32767), $urandom_range(0, 15));
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    r = $urandom_range(0, n - 1);
                    c = $urandom_range(0, n - 1);
                    send_item(pmst_pkg::CMD_LOAD, r, c, pick_weight(sparse_pct),
                              $urandom_range(0, 15));
                end
                if ($urandom_range(0, 6) == 0)
                    run_tree($urandom_range(0, 15));
                else
                    run_tree($urandom_range(0, n - 1));
            end
            graph_idx++;
        end

        // full vertex count, first through a count above the maximum; only rows
        // 14 and 15 are read, one edge between them and nothing else reachable
        quiet = 1'b0;
        write_vertex_count(31);
        edge_w = $urandom_range(1, 32766);
        for (r = 14; r < 16; r++)
        begin
            for (c = 0; c < 16; c++)
            begin
                if (c == r)
                    send_item(pmst_pkg::CMD_LOAD, r, c, 0, 0);
                else if (c + r == 29)
                    send_item(pmst_pkg::CMD_LOAD, r, c, edge_w, 0);
                else
                    send_item(pmst_pkg::CMD_LOAD, r, c, int'(pmst_pkg::NO_EDGE), 0);
            end
        end
        run_tree(15);
        run_tree(14);
        write_vertex_count(16);
        run_tree(15);

        s_tvalid <= 1'b0;
        while (sb.pending_edges.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fails == 0)
            $display("tb_prim_minimum_spanning_tree OK");
        else
            $display("tb_prim_minimum_spanning_tree NOT OK");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/pmst_pkg.sv
rtl/pmst_scan.sv
rtl/prim_minimum_spanning_tree.sv
sim/tb_prim_minimum_spanning_tree.sv
